// ===== rtl/tlb_lru_replacement_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TLB_LRU_REPLACEMENT_DEFINES_SVH
`define TLB_LRU_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLBLRU_ASSERT_IMPLY(label, clk, rstn, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
    else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLBLRU_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
    else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/tlblru_pkg.sv =====
package tlblru_pkg;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int ADDR_BITS_DEF   = 32;

  localparam int CFG_W          = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int MIN_PAGE_SHIFT = 10;
  localparam int EVICT_W        = 22;
  localparam int COUNT_W        = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] CAPACITY_RST   = CFG_W'(16);
  localparam logic [CFG_W-1:0] PAGE_SHIFT_RST = CFG_W'(12);

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

  // Carried from each cell to the next older one during a lookup.
  typedef struct packed {
    logic               stop;     // a younger cell matched or is the last in use
    logic               hit;      // a younger cell matched
    logic               full;     // the last cell in use holds a page
    logic [EVICT_W-1:0] ev_page;  // page of the last cell in use
  } chain_t;

endpackage

// ===== rtl/tlblru_cell.sv =====
module tlblru_cell #(
  parameter int IDX    = 0,
  parameter int IDX_W  = 4,
  parameter int PAGE_W = 22
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  upd_i,
  input  logic [IDX_W-1:0]      last_i,
  input  logic [PAGE_W-1:0]     look_page_i,
  input  logic [PAGE_W-1:0]     prev_page_i,
  input  logic                  prev_valid_i,
  output logic [PAGE_W-1:0]     page_o,
  output logic                  valid_o,
  input  tlblru_pkg::chain_t    chain_i,
  output tlblru_pkg::chain_t    chain_o
);
  import tlblru_pkg::*;

  logic [PAGE_W-1:0] page_q, page_d;
  logic              valid_q, valid_d;
  logic              in_use, is_last, eff_valid, match;

  assign in_use    = (IDX_W'(IDX) <= last_i);
  assign is_last   = (IDX_W'(IDX) == last_i);
  assign eff_valid = valid_q & in_use;
  assign match     = eff_valid & (page_q == look_page_i);

  always_comb begin
    chain_o.stop    = chain_i.stop | match | is_last;
    chain_o.hit     = chain_i.hit | match;
    chain_o.full    = chain_i.full | (is_last & eff_valid);
    chain_o.ev_page = chain_i.ev_page | (is_last ? EVICT_W'(page_q) : '0);
  end

  // Take the younger neighbour's entry unless the shift stopped above us.
  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    if (upd_i) begin
      if (!chain_i.stop) begin
        page_d  = prev_page_i;
        valid_d = prev_valid_i;
      end else begin
        valid_d = eff_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign page_o  = page_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/tlb_lru_replacement.sv =====
// Fully associative TLB tag store with least-recently-used replacement.
// Request channel: in_valid_i / in_stall_o with address_i. A request is taken
// on a rising edge with in_valid_i high and in_stall_o low.
// Result channel: out_valid_o / out_stall_i with hit_o, evicted_valid_o,
// evicted_page_o and hit_total_o; one result per request, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 capacity, 1 page shift); other indexes are ignored. Write only when idle.
// Timing: the request is latched into the lookup register, the row of cells
// is searched and updated in the lookup state, and the result is registered
// as the lookup completes. The block holds one request at a time: a new
// request is taken only after the lookup state returns to idle.
// If the receiver stalls with a result still held, the lookup waits in the
// lookup state until the output register frees; requests stall meanwhile.
// Reset clears the cell valid bits, the output valid bit and the hit counter,
// and loads capacity 16 and page shift 12; the block is ready once reset is released.
module tlb_lru_replacement #(
  parameter int TLB_ENTRIES = tlblru_pkg::TLB_ENTRIES_DEF,
  parameter int ADDR_BITS   = tlblru_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ADDR_BITS-1:0]             address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic                             evicted_valid_o,
  output logic [tlblru_pkg::EVICT_W-1:0]   evicted_page_o,
  output logic [tlblru_pkg::COUNT_W-1:0]   hit_total_o,
  input  logic                             cfg_we_i,
  input  logic [tlblru_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tlblru_pkg::CFG_W-1:0]     cfg_data_i
);
  import tlblru_pkg::*;

  localparam int PAGE_W = ADDR_BITS - MIN_PAGE_SHIFT;
  localparam int IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  state_e state_q, state_d;

  logic [CFG_W-1:0]   capacity_q, page_shift_q, shift_eff;
  logic [IDX_W-1:0]   last_idx;
  logic [PAGE_W-1:0]  look_page_q;
  logic [COUNT_W-1:0] hit_count_q;
  logic               out_valid_q, hit_q, ev_valid_q;
  logic [EVICT_W-1:0] ev_page_q;
  logic               accept, commit, out_free;

  logic [PAGE_W-1:0]  cell_page  [TLB_ENTRIES];
  logic               cell_valid [TLB_ENTRIES];
  chain_t             chain      [TLB_ENTRIES+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= CAPACITY_RST;
      page_shift_q <= PAGE_SHIFT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_CAPACITY) begin
        capacity_q <= cfg_data_i;
      end else if (cfg_index_i == REG_PAGE_SHIFT) begin
        page_shift_q <= cfg_data_i;
      end
    end
  end

  // Clamp the page shift from below; larger shifts stand as written.
  assign shift_eff = (page_shift_q < CFG_W'(MIN_PAGE_SHIFT)) ? CFG_W'(MIN_PAGE_SHIFT)
                                                             : page_shift_q;

  // Index of the oldest entry in use: capacity zero acts as one, and the
  // capacity saturates at the built depth.
  always_comb begin
    priority if (capacity_q == '0) begin
      last_idx = '0;
    end else if (32'(capacity_q) > 32'(TLB_ENTRIES)) begin
      last_idx = IDX_W'(TLB_ENTRIES - 1);
    end else begin
      last_idx = IDX_W'(capacity_q - CFG_W'(1));
    end
  end

  // Handshake control.
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign commit   = (state_q == ST_LOOK) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: if (out_free)   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_LOOK: in_stall_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the page number of the incoming request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      look_page_q <= PAGE_W'(address_i >> shift_eff);
    end
  end

  // Row of cells, youngest first; the lookup page enters at the young end.
  assign chain[0] = '{stop: 1'b0, hit: 1'b0, full: 1'b0, ev_page: '0};

  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    logic [PAGE_W-1:0] prev_page;
    logic              prev_valid;

    if (g == 0) begin : g_head
      assign prev_page  = look_page_q;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_page  = cell_page[g-1];
      assign prev_valid = cell_valid[g-1];
    end

    tlblru_cell #(
      .IDX    (g),
      .IDX_W  (IDX_W),
      .PAGE_W (PAGE_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .upd_i        (commit),
      .last_i       (last_idx),
      .look_page_i  (look_page_q),
      .prev_page_i  (prev_page),
      .prev_valid_i (prev_valid),
      .page_o       (cell_page[g]),
      .valid_o      (cell_valid[g]),
      .chain_i      (chain[g]),
      .chain_o      (chain[g+1])
    );
  end

  // Valid bit and hit counter; the counter moves only on a completed lookup.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_count_q <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
        if (chain[TLB_ENTRIES].hit) begin
          hit_count_q <= hit_count_q + COUNT_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q      <= chain[TLB_ENTRIES].hit;
      ev_valid_q <= chain[TLB_ENTRIES].full & ~chain[TLB_ENTRIES].hit;
      ev_page_q  <= (chain[TLB_ENTRIES].full & ~chain[TLB_ENTRIES].hit)
                    ? chain[TLB_ENTRIES].ev_page : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign hit_total_o     = hit_count_q;

endmodule

// ===== rtl/tlblru_checker.sv =====
module tlblru_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             hit_o,
  input logic                             evicted_valid_o,
  input logic [tlblru_pkg::EVICT_W-1:0]   evicted_page_o,
  input logic [tlblru_pkg::COUNT_W-1:0]   hit_total_o
);
  `include "tlb_lru_replacement_defines.svh"

  // A hit never evicts.
  `TLBLRU_ASSERT_IMPLY(a_hit_no_evict, clk_i, rst_ni, out_valid_o && hit_o, !evicted_valid_o)

  // Without an eviction the reported page is zero.
  `TLBLRU_ASSERT_IMPLY(a_evict_page_zero, clk_i, rst_ni, out_valid_o && !evicted_valid_o, evicted_page_o == '0)

  // One request in flight: a taken request stalls the next cycle.
  `TLBLRU_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A held result stays valid and keeps its hit flag and hit total.
  `TLBLRU_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(hit_total_o) && $stable(hit_o))

endmodule

bind tlb_lru_replacement tlblru_checker u_tlblru_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .hit_o           (hit_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o),
  .hit_total_o     (hit_total_o)
);
